// ===== rtl/afwn_pkg.sv =====
// ----------------------------------------------------------------------------
// afwn_pkg
// Shared types, byte codes and the Latin-1 fold table for the accent-folding
// word normalizer.
// ----------------------------------------------------------------------------
package afwn_pkg;

  // UTF-8 lead bytes that take the following byte as partner
  localparam logic [7:0] LEAD_PLAIN = 8'd194;
  localparam logic [7:0] LEAD_LATIN = 8'd195;

  // Word separator
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // Pending lead codes
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PLAIN = 2'd1;
  localparam logic [1:0] PEND_LATIN = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One queued step: optional leading space plus one word character
  typedef struct packed {
    logic       has_space;
    logic [7:0] ch;
  } entry_t;

  // Folded letter for the byte after a Latin lead, zero when unmapped
  function automatic logic [7:0] fold_latin(input logic [7:0] b);
    logic [7:0] f;
    f = 8'd0;
    if ((b >= 8'd160 && b <= 8'd163) || (b >= 8'd128 && b <= 8'd131)) begin
      f = 8'h61;
    end else if ((b >= 8'd168 && b <= 8'd170) || (b >= 8'd136 && b <= 8'd138)) begin
      f = 8'h65;
    end else if (b == 8'd172 || b == 8'd173 || b == 8'd140 || b == 8'd141) begin
      f = 8'h69;
    end else if ((b >= 8'd178 && b <= 8'd181) || (b >= 8'd146 && b <= 8'd149)) begin
      f = 8'h6f;
    end else if (b == 8'd186 || b == 8'd187 || b == 8'd154 || b == 8'd155) begin
      f = 8'h75;
    end else if (b == 8'd167 || b == 8'd135) begin
      f = 8'h63;
    end
    return f;
  endfunction

endpackage

// ===== rtl/afwn_front.sv =====
// ----------------------------------------------------------------------------
// afwn_front
// Accepts input bytes, classifies them and tracks word state; produces one
// queue entry for every byte that yields word output.
// ----------------------------------------------------------------------------
module afwn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                end_of_text,
  input  logic                q_full,
  output logic                push,
  output afwn_pkg::entry_t    push_entry
);

  logic [1:0] pending_lead, pending_lead_next;
  logic       inside_word, inside_word_next;
  logic       word_emitted_before, word_emitted_before_next;
  logic       accept;
  logic       emit;
  logic [7:0] emit_ch;
  logic [7:0] folded;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign folded   = afwn_pkg::fold_latin(in_byte);

  // Classify the byte and compute the next word state
  always_comb begin
    emit                     = 1'b0;
    emit_ch                  = in_byte;
    pending_lead_next        = afwn_pkg::PEND_NONE;
    inside_word_next         = inside_word;
    word_emitted_before_next = word_emitted_before;

    if (pending_lead == afwn_pkg::PEND_PLAIN || pending_lead == afwn_pkg::PEND_LATIN) begin
      // partner byte: fold after a Latin lead, else drop
      if (pending_lead == afwn_pkg::PEND_LATIN && folded != 8'd0) begin
        emit    = 1'b1;
        emit_ch = folded;
      end
    end else if (in_byte == afwn_pkg::LEAD_PLAIN) begin
      pending_lead_next = afwn_pkg::PEND_PLAIN;
    end else if (in_byte == afwn_pkg::LEAD_LATIN) begin
      pending_lead_next = afwn_pkg::PEND_LATIN;
    end else if (in_byte >= 8'h41 && in_byte <= 8'h5a) begin
      emit    = 1'b1;
      emit_ch = in_byte + 8'd32;
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h7a) ||
                 (in_byte >= 8'h30 && in_byte <= 8'h39)) begin
      emit = 1'b1;
    end else begin
      inside_word_next = 1'b0;
    end

    // open a word; later words get a leading space
    push_entry.has_space = emit && !inside_word && word_emitted_before;
    push_entry.ch        = emit_ch;
    if (emit) begin
      inside_word_next         = 1'b1;
      word_emitted_before_next = 1'b1;
    end

    // drop all state after the last byte of a document
    if (end_of_text) begin
      pending_lead_next        = afwn_pkg::PEND_NONE;
      inside_word_next         = 1'b0;
      word_emitted_before_next = 1'b0;
    end
  end

  assign push = accept && emit;

  // Advance word state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead        <= afwn_pkg::PEND_NONE;
      inside_word         <= 1'b0;
      word_emitted_before <= 1'b0;
    end else if (accept) begin
      pending_lead        <= pending_lead_next;
      inside_word         <= inside_word_next;
      word_emitted_before <= word_emitted_before_next;
    end
  end

endmodule

// ===== rtl/afwn_queue.sv =====
// ----------------------------------------------------------------------------
// afwn_queue
// Short register queue of word entries between the front and the back.
// ----------------------------------------------------------------------------
module afwn_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  afwn_pkg::entry_t    push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output afwn_pkg::entry_t    head
);

  afwn_pkg::entry_t                  slots [afwn_pkg::QUEUE_DEPTH];
  logic [afwn_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [afwn_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [afwn_pkg::QUEUE_CW-1:0]     count;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count == afwn_pkg::QUEUE_CW'(afwn_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == afwn_pkg::QUEUE_AW'(afwn_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == afwn_pkg::QUEUE_AW'(afwn_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/afwn_back.sv =====
// ----------------------------------------------------------------------------
// afwn_back
// Expands each queue entry into output beats: an optional space, then the
// word character flagged as last.
// ----------------------------------------------------------------------------
module afwn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  afwn_pkg::entry_t    head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                last
);

  logic space_done;
  logic space_phase;
  logic accept;

  assign space_phase = head.has_space && !space_done;
  assign out_valid   = !q_empty;
  assign out_char    = space_phase ? afwn_pkg::CHAR_SPACE : head.ch;
  assign last        = !space_phase;
  assign accept      = out_valid && out_ready;
  assign pop         = accept && !space_phase;

  // Track whether the leading space of the head entry has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      space_done <= 1'b0;
    end else if (accept) begin
      space_done <= space_phase;
    end
  end

endmodule

// ===== rtl/accent_folding_word_normalizer.sv =====
// ----------------------------------------------------------------------------
// accent_folding_word_normalizer
// Turns a UTF-8 byte stream into lowercase words separated by single spaces.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one text byte per beat plus end_of_text
// on the final byte of a document. Letters and digits are lowercased and
// kept, mapped accented vowels and c-cedilla after lead 195 fold to plain
// letters, other pairs after 194/195 are dropped, other bytes end the word.
// Output channel (out_valid/out_ready): one character per beat; last marks
// the final character produced by an input byte. A byte yields zero, one or
// two beats (a space ahead of each word after the first).
// With the queue empty, the first beat of a byte is offered in the cycle
// after the byte is accepted; a character behind a space follows in the
// cycle after the space is taken. One byte is accepted per cycle while the
// queue is not full; a byte that opens a later word needs a space beat and
// a character beat on the output.
// A two-entry queue sits between input decode and output expansion, so input
// keeps flowing while a result waits; in_ready drops only when it is full.
// Reset (rst, synchronous) empties the queue and clears word state;
// end_of_text clears word state after its byte.
// ----------------------------------------------------------------------------
module accent_folding_word_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  afwn_pkg::entry_t push_entry;
  afwn_pkg::entry_t head;

  // Decode input bytes
  afwn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .q_full      (q_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Decouple decode from output
  afwn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // Expand entries into output beats
  afwn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

// ===== tb/sv/afwn_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afwn_stream_checker
// Watches both channels of the word normalizer, folds each accepted input
// byte into the characters it should produce and compares every output beat,
// in order, with the oldest of those characters.
// ----------------------------------------------------------------------------
module afwn_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       last,
  output int         errors,
  output int         open_results,
  output int         bytes_seen,
  output int         chars_seen,
  output int         docs_seen
);

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // Characters still owed by the block, oldest first
  char_beat_t expected_chars[$];

  // Text state as the block should hold it
  logic [1:0] lead_seen;
  logic       in_word;
  logic       had_word;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Append one owed character at the tail
  task automatic owe_char(input logic [7:0] ch, input logic is_last);
    char_beat_t beat;
    beat.ch   = ch;
    beat.last = is_last;
    expected_chars.insert(expected_chars.size(), beat);
  endtask

  // Plain letter for a partner byte after the Latin lead, zero when unmapped.
  // Upper and lower case forms sit 32 apart, so fold on the low five bits.
  function automatic logic [7:0] plain_letter(input logic [7:0] b);
    if (b[7:6] != 2'b10) begin
      return 8'd0;
    end
    case (b[4:0])
      5'd0, 5'd1, 5'd2, 5'd3:     return "a";
      5'd7:                       return "c";
      5'd8, 5'd9, 5'd10:          return "e";
      5'd12, 5'd13:               return "i";
      5'd18, 5'd19, 5'd20, 5'd21: return "o";
      5'd26, 5'd27:               return "u";
      default:                    return 8'd0;
    endcase
  endfunction

  // Advance the text state by one byte and queue what it produces
  task automatic predict_byte(input logic [7:0] b, input logic eot);
    logic [7:0] word_ch;
    word_ch = 8'd0;
    if (lead_seen == afwn_pkg::PEND_PLAIN || lead_seen == afwn_pkg::PEND_LATIN) begin
      // partner byte: always consumed, only Latin pairs may fold
      if (lead_seen == afwn_pkg::PEND_LATIN) begin
        word_ch = plain_letter(b);
      end
      lead_seen = afwn_pkg::PEND_NONE;
    end else begin
      lead_seen = afwn_pkg::PEND_NONE;
      if (b == afwn_pkg::LEAD_PLAIN) begin
        lead_seen = afwn_pkg::PEND_PLAIN;
      end else if (b == afwn_pkg::LEAD_LATIN) begin
        lead_seen = afwn_pkg::PEND_LATIN;
      end else if (b >= "A" && b <= "Z") begin
        word_ch = b + 8'd32;
      end else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
        word_ch = b;
      end else begin
        in_word = 1'b0;
      end
    end
    if (word_ch != 8'd0) begin
      // open a word, with a separating space after the first one
      if (!in_word) begin
        if (had_word) begin
          owe_char(afwn_pkg::CHAR_SPACE, 1'b0);
        end
        in_word  = 1'b1;
        had_word = 1'b1;
      end
      owe_char(word_ch, 1'b1);
    end
    if (eot) begin
      lead_seen = afwn_pkg::PEND_NONE;
      in_word   = 1'b0;
      had_word  = 1'b0;
    end
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    char_beat_t want;
    if (rst) begin
      lead_seen  = afwn_pkg::PEND_NONE;
      in_word    = 1'b0;
      had_word   = 1'b0;
      errors     = 0;
      bytes_seen = 0;
      chars_seen = 0;
      docs_seen  = 0;
      expected_chars.delete();
    end else begin
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        bytes_seen++;
        if (end_of_text) begin
          docs_seen++;
        end
        predict_byte(in_byte, end_of_text);
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected char 0x%02h last %0b", out_char, last));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            report($sformatf("char 0x%02h, want 0x%02h", out_char, want.ch));
          end
          if (last !== want.last) begin
            report($sformatf("last %0b on char 0x%02h, want %0b",
                             last, out_char, want.last));
          end
        end
      end
    end
    open_results = expected_chars.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives text bytes into the accent-folding word normalizer: a directed run
// over letters, digits, lead pairs, folds and document ends, then random
// text of letters, digits, lead pairs and other bytes. Both channels idle at
// random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BYTES = 800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_text;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       last;

  int errors;
  int open_results;
  int bytes_seen;
  int chars_seen;
  int docs_seen;
  int cycles = 0;
  logic calm;

  accent_folding_word_normalizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last        (last)
  );

  afwn_stream_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last         (last),
    .errors       (errors),
    .open_results (open_results),
    .bytes_seen   (bytes_seen),
    .chars_seen   (chars_seen),
    .docs_seen    (docs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still owed", cycles, open_results);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 82) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Hold one byte until its beat is taken, then idle for a random gap, if any
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Output stalls: runs of ready, sometimes long, broken by random stalls
  initial begin : ready_gen
    int run;
    int stall;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      while (rst) @(posedge clk);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  initial begin : stim
    int sent;
    int r;
    logic eot;
    logic lead_eot;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_byte     <= 8'd0;
    end_of_text <= 1'b0;
    calm        = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: case folding, word breaks, lead pairs, document ends
    send_byte("A", 1'b0);
    send_byte("b", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("Z", 1'b0);
    send_byte(8'h9f, 1'b0);        // high non-lead byte ends the word
    send_byte(afwn_pkg::LEAD_LATIN, 1'b0);
    send_byte(8'd160, 1'b0);       // folded letter opens a word
    send_byte(afwn_pkg::LEAD_LATIN, 1'b0);
    send_byte(8'd135, 1'b0);       // folded c-cedilla joins the word
    send_byte(afwn_pkg::LEAD_PLAIN, 1'b0);
    send_byte("A", 1'b0);          // pair after the plain lead is dropped
    send_byte("9", 1'b0);          // word still open: no space
    send_byte(afwn_pkg::LEAD_LATIN, 1'b0);
    send_byte(afwn_pkg::LEAD_LATIN, 1'b0);   // lead as partner, unmapped
    send_byte("0", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(afwn_pkg::LEAD_LATIN, 1'b0);
    send_byte("a", 1'b0);          // ASCII partner swallowed
    send_byte("z", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(afwn_pkg::LEAD_LATIN, 1'b1);   // lead dropped by end of text
    send_byte("9", 1'b0);          // first word of a new document
    send_byte(afwn_pkg::LEAD_PLAIN, 1'b0);
    send_byte(afwn_pkg::LEAD_PLAIN, 1'b0);
    send_byte("y", 1'b1);

    // Random text, in blocks that each run as a burst or with random gaps
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent % 50 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      r        = $urandom_range(0, 99);
      eot      = ($urandom_range(0, 49) == 0);
      lead_eot = ($urandom_range(0, 99) == 0);
      if (r < 30) begin
        send_byte(8'($urandom_range(0, 1) ? $urandom_range(65, 90)
                                          : $urandom_range(97, 122)), eot);
        sent += 1;
      end else if (r < 40) begin
        send_byte(8'($urandom_range(48, 57)), eot);
        sent += 1;
      end else if (r < 60) begin
        send_byte(afwn_pkg::LEAD_LATIN, lead_eot);
        send_byte(8'($urandom_range(128, 191)), eot);
        sent += 2;
      end else if (r < 65) begin
        send_byte(afwn_pkg::LEAD_LATIN, lead_eot);
        send_byte(8'($urandom_range(0, 255)), eot);
        sent += 2;
      end else if (r < 70) begin
        send_byte(afwn_pkg::LEAD_PLAIN, lead_eot);
        send_byte(8'($urandom_range(0, 255)), eot);
        sent += 2;
      end else if (r < 82) begin
        send_byte($urandom_range(0, 1) ? afwn_pkg::CHAR_SPACE
                                       : 8'($urandom_range(33, 47)), eot);
        sent += 1;
      end else begin
        send_byte(8'($urandom_range(0, 255)), eot);
        sent += 1;
      end
    end
    in_valid <= 1'b0;

    // Drain the owed characters, then watch for strays
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input bytes over %0d documents, %0d output characters",
             bytes_seen, docs_seen, chars_seen);
    $display("%0d mismatches in %0d cycles", errors, cycles);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/afwn_pkg.sv
rtl/afwn_front.sv
rtl/afwn_queue.sv
rtl/afwn_back.sv
rtl/accent_folding_word_normalizer.sv
tb/sv/afwn_stream_checker.sv
tb/sv/tb.sv
